// ----- hw/rtl/sci_pkg.sv -----
`timescale 1ns / 1ps
// Package for the shape correction interpolator: payload types, segment tables,
// stage control struct and divider constants. No dependencies.
package sci_pkg;

	localparam int ARG_W   = 23;
	localparam int COEFF_W = 17;

	localparam logic [1:0] MODE_RECT = 2'd0;
	localparam logic [1:0] MODE_TRI  = 2'd1;
	localparam logic [1:0] MODE_ELL  = 2'd2;

	localparam int NSEG_RECT = 6;
	localparam int NSEG_TRI  = 7;
	localparam int NSEG_ELL  = 9;

	localparam int MQ_W      = 28;
	localparam int RECIP_W   = 24;
	localparam logic [RECIP_W-1:0] RECIP_25  = 24'd10737418;
	localparam logic [RECIP_W-1:0] RECIP_125 = 24'd2147483;
	localparam logic [6:0] DIV_25  = 7'd25;
	localparam logic [6:0] DIV_125 = 7'd125;
	localparam logic [COEFF_W-1:0] COEFF_MAX = 17'h1FFFF;

	typedef struct packed {
		logic [1:0]       mode;
		logic [ARG_W-1:0] arg;
	} cmd_t;

	typedef struct packed {
		logic [COEFF_W-1:0] coeff;
		logic               status;
	} result_t;

	typedef struct packed {
		logic [6:0]        xs;
		logic [6:0]        ys;
		logic [4:0]        w;
		logic signed [4:0] dy;
		logic [2:0]        sh;
		logic              m125;
		logic              scale10;
	} seg_t;

	typedef struct packed {
		logic             err;
		seg_t             seg;
		logic [ARG_W-1:0] arg;
	} sel_t;

	typedef struct packed {
		logic       err;
		logic [2:0] sh;
		logic       m125;
	} ctl_t;

	function automatic int cmp_width(int frac);
		return (frac + 8 > ARG_W) ? frac + 8 : ARG_W + 1;
	endfunction

	function automatic int num_width(int frac);
		return cmp_width(frac) + 10;
	endfunction

	// Each segment: start, start value in hundredths, width, rise, and the split of
	// 100 * width into a power of two and a factor of 25 or 125.
	function automatic seg_t seg_lookup(logic [1:0] mode, logic [3:0] idx);
		seg_t s;
		s = '0;
		case ({mode, idx})
			{MODE_RECT, 4'd0}: s = '{7'd0,  7'd110, 5'd1,  -5'sd2, 3'd2, 1'b0, 1'b1};
			{MODE_RECT, 4'd1}: s = '{7'd1,  7'd108, 5'd1,  -5'sd2, 3'd2, 1'b0, 1'b1};
			{MODE_RECT, 4'd2}: s = '{7'd2,  7'd106, 5'd2,  -5'sd2, 3'd3, 1'b0, 1'b1};
			{MODE_RECT, 4'd3}: s = '{7'd4,  7'd104, 5'd2,  -5'sd2, 3'd3, 1'b0, 1'b1};
			{MODE_RECT, 4'd4}: s = '{7'd6,  7'd102, 5'd2,  -5'sd1, 3'd3, 1'b0, 1'b1};
			{MODE_RECT, 4'd5}: s = '{7'd8,  7'd101, 5'd2,  -5'sd1, 3'd3, 1'b0, 1'b1};
			{MODE_TRI,  4'd0}: s = '{7'd0,  7'd75,  5'd10, 5'sd9,  3'd3, 1'b1, 1'b0};
			{MODE_TRI,  4'd1}: s = '{7'd10, 7'd84,  5'd10, 5'sd5,  3'd3, 1'b1, 1'b0};
			{MODE_TRI,  4'd2}: s = '{7'd20, 7'd89,  5'd10, 5'sd4,  3'd3, 1'b1, 1'b0};
			{MODE_TRI,  4'd3}: s = '{7'd30, 7'd93,  5'd10, 5'sd3,  3'd3, 1'b1, 1'b0};
			{MODE_TRI,  4'd4}: s = '{7'd40, 7'd96,  5'd20, 5'sd2,  3'd4, 1'b1, 1'b0};
			{MODE_TRI,  4'd5}: s = '{7'd60, 7'd98,  5'd20, 5'sd1,  3'd4, 1'b1, 1'b0};
			{MODE_TRI,  4'd6}: s = '{7'd80, 7'd99,  5'd10, 5'sd1,  3'd3, 1'b1, 1'b0};
			{MODE_ELL,  4'd0}: s = '{7'd1,  7'd121, 5'd1,  -5'sd5, 3'd2, 1'b0, 1'b1};
			{MODE_ELL,  4'd1}: s = '{7'd2,  7'd116, 5'd1,  -5'sd5, 3'd2, 1'b0, 1'b1};
			{MODE_ELL,  4'd2}: s = '{7'd3,  7'd111, 5'd1,  -5'sd3, 3'd2, 1'b0, 1'b1};
			{MODE_ELL,  4'd3}: s = '{7'd4,  7'd108, 5'd1,  -5'sd3, 3'd2, 1'b0, 1'b1};
			{MODE_ELL,  4'd4}: s = '{7'd5,  7'd105, 5'd1,  -5'sd2, 3'd2, 1'b0, 1'b1};
			{MODE_ELL,  4'd5}: s = '{7'd6,  7'd103, 5'd1,  -5'sd1, 3'd2, 1'b0, 1'b1};
			{MODE_ELL,  4'd6}: s = '{7'd7,  7'd102, 5'd1,  -5'sd1, 3'd2, 1'b0, 1'b1};
			{MODE_ELL,  4'd7}: s = '{7'd8,  7'd101, 5'd1,  5'sd0,  3'd2, 1'b0, 1'b1};
			{MODE_ELL,  4'd8}: s = '{7'd9,  7'd101, 5'd1,  -5'sd1, 3'd2, 1'b0, 1'b1};
			default:           s = '0;
		endcase
		return s;
	endfunction

endpackage

// ----- hw/rtl/shape_correction_interpolator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the shape correction interpolator: a six-stage pipeline built from
// sci_seg_select, sci_line_eval and sci_recip_div. Depends on sci_pkg.
//
// Usage:
// An item is a shape selector and an argument on cmd. It is taken at a rising edge
// where start is high and busy is low. Busy is always low, so one item may be
// given in every cycle.
// Each item gives exactly one result on result, shown for one cycle with done high.
// The result passes through six register stages (range check and segment search,
// offset, line numerator, shift, reciprocal multiply, correction). Throughput is one
// item per cycle.
// The receiver cannot hold results off, and the pipeline never stalls.
// An argument out of range for its shape, or an unused selector, gives status 1
// and a zero coefficient.
// Reset clears all valid bits; items in flight at reset are dropped and done stays
// low until a new item has passed the pipeline.
module shape_correction_interpolator_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sci_pkg::cmd_t    cmd,
	output logic             done,
	output sci_pkg::result_t result
);

	localparam int NUM_W = sci_pkg::num_width(FRAC_BITS);

	logic                    valid_s1, valid_s3;
	sci_pkg::sel_t           sel_s1;
	sci_pkg::ctl_t           ctl_s3;
	logic signed [NUM_W-1:0] num_s3;

	assign busy = 1'b0;

	sci_seg_select #(.FRAC_BITS(FRAC_BITS)) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.cmd      (cmd),
		.valid_s1 (valid_s1),
		.sel_s1   (sel_s1)
	);

	sci_line_eval #(.FRAC_BITS(FRAC_BITS)) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.sel_s1   (sel_s1),
		.valid_s3 (valid_s3),
		.ctl_s3   (ctl_s3),
		.num_s3   (num_s3)
	);

	sci_recip_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.ctl_s3    (ctl_s3),
		.num_s3    (num_s3),
		.valid_s6  (done),
		.result_s6 (result)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 done)
		else $error("Item taken without a result six cycles later.");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("Result without an item taken six cycles earlier.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (result.coeff == '0))
		else $error("Error result carries a nonzero coefficient.");

	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.status) |-> (result.coeff != '0))
		else $error("Valid result carries a zero coefficient.");

endmodule

// ----- hw/rtl/sci_seg_select.sv -----
`timescale 1ns / 1ps
// Stage 1: range check of the argument and breakpoint search for the selected shape.
// Depends on sci_pkg.
module sci_seg_select #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  sci_pkg::cmd_t cmd,
	output logic          valid_s1,
	output sci_pkg::sel_t sel_s1
);

	localparam int CMP_W = sci_pkg::cmp_width(FRAC_BITS);
	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam logic [CMP_W-1:0] E_MIN    = CMP_W'((ONE + 99999) / 100000);
	localparam logic [CMP_W-1:0] RECT_MAX = CMP_W'(ONE);
	localparam logic [CMP_W-1:0] TRI_LIM  = CMP_W'(90 * ONE - (ONE + 99999) / 100000 + 1);
	localparam logic [CMP_W-1:0] ELL_MAX  = CMP_W'(ONE + ONE / 100000);

	logic [CMP_W-1:0]               r;
	logic [sci_pkg::NSEG_RECT-2:0] ge_r;
	logic [sci_pkg::NSEG_TRI-2:0]  ge_t;
	logic [sci_pkg::NSEG_ELL-2:0]  ge_e;
	logic [3:0]                     cnt_r, cnt_t, cnt_e, idx;
	logic                           ok;
	sci_pkg::sel_t                  sel_d;

	assign r = CMP_W'(cmd.arg);

	for (genvar g = 1; g < sci_pkg::NSEG_RECT; g++) begin : g_rect
		localparam sci_pkg::seg_t SG = sci_pkg::seg_lookup(sci_pkg::MODE_RECT, 4'(g));
		localparam longint T = (longint'(SG.xs) * ONE + 9) / 10;
		assign ge_r[g-1] = r >= CMP_W'(T);
	end

	for (genvar g = 1; g < sci_pkg::NSEG_TRI; g++) begin : g_tri
		localparam sci_pkg::seg_t SG = sci_pkg::seg_lookup(sci_pkg::MODE_TRI, 4'(g));
		localparam longint T = longint'(SG.xs) * ONE;
		assign ge_t[g-1] = r >= CMP_W'(T);
	end

	for (genvar g = 1; g < sci_pkg::NSEG_ELL; g++) begin : g_ell
		localparam sci_pkg::seg_t SG = sci_pkg::seg_lookup(sci_pkg::MODE_ELL, 4'(g));
		localparam longint T = (longint'(SG.xs) * ONE + 9) / 10;
		assign ge_e[g-1] = r >= CMP_W'(T);
	end

	// Breakpoints rise, so the compare results form a thermometer code.
	always_comb begin
		cnt_r = '0;
		cnt_t = '0;
		cnt_e = '0;
		for (int i = 0; i < sci_pkg::NSEG_RECT - 1; i++) cnt_r = cnt_r + 4'(ge_r[i]);
		for (int i = 0; i < sci_pkg::NSEG_TRI - 1; i++) cnt_t = cnt_t + 4'(ge_t[i]);
		for (int i = 0; i < sci_pkg::NSEG_ELL - 1; i++) cnt_e = cnt_e + 4'(ge_e[i]);
		case (cmd.mode)
			sci_pkg::MODE_RECT: begin
				idx = cnt_r;
				ok  = r <= RECT_MAX;
			end
			sci_pkg::MODE_TRI: begin
				idx = cnt_t;
				ok  = r < TRI_LIM;
			end
			sci_pkg::MODE_ELL: begin
				idx = cnt_e;
				ok  = r <= ELL_MAX;
			end
			default: begin
				idx = '0;
				ok  = 1'b0;
			end
		endcase
		sel_d.err = !(ok && (r >= E_MIN));
		sel_d.seg = sci_pkg::seg_lookup(cmd.mode, idx);
		sel_d.arg = cmd.arg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1 <= sel_d;
	end

endmodule

// ----- hw/rtl/sci_line_eval.sv -----
`timescale 1ns / 1ps
// Stages 2 and 3: offset from the segment start and the scaled line numerator.
// Depends on sci_pkg.
module sci_line_eval #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            valid_s1,
	input  sci_pkg::sel_t                                   sel_s1,
	output logic                                            valid_s3,
	output sci_pkg::ctl_t                                   ctl_s3,
	output logic signed [sci_pkg::num_width(FRAC_BITS)-1:0] num_s3
);

	localparam int CMP_W = sci_pkg::cmp_width(FRAC_BITS);
	localparam int D_W   = CMP_W + 4;
	localparam int NUM_W = sci_pkg::num_width(FRAC_BITS);

	logic [D_W-1:0]        ax, ax_scaled, x_off;
	logic [11:0]           base;
	logic                  valid_s2;
	logic signed [D_W-1:0] d_s2;
	logic [11:0]           base_s2;
	logic signed [4:0]     dy_s2;
	sci_pkg::ctl_t         ctl_s2;
	logic [NUM_W-1:0]      num_d;

	always_comb begin
		ax        = D_W'(sel_s1.arg);
		ax_scaled = sel_s1.seg.scale10 ? (ax << 3) + (ax << 1) : ax;
		x_off     = D_W'(sel_s1.seg.xs) << FRAC_BITS;
		base      = 12'(sel_s1.seg.ys) * 12'(sel_s1.seg.w);
	end

	assign num_d = (NUM_W'(base_s2) << FRAC_BITS) + NUM_W'(dy_s2) * NUM_W'(d_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s2        <= signed'(ax_scaled - x_off);
		base_s2     <= base;
		dy_s2       <= sel_s1.seg.dy;
		ctl_s2.err  <= sel_s1.err;
		ctl_s2.sh   <= sel_s1.seg.sh;
		ctl_s2.m125 <= sel_s1.seg.m125;
		num_s3      <= signed'(num_d);
		ctl_s3      <= ctl_s2;
	end

endmodule

// ----- hw/rtl/sci_recip_div.sv -----
`timescale 1ns / 1ps
// Stages 4 to 6: exact floor division of the numerator by 100 times the segment width,
// done as a shift and a reciprocal multiply with one correction step. Depends on sci_pkg.
module sci_recip_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            valid_s3,
	input  sci_pkg::ctl_t                                   ctl_s3,
	input  logic signed [sci_pkg::num_width(FRAC_BITS)-1:0] num_s3,
	output logic                                            valid_s6,
	output sci_pkg::result_t                                result_s6
);

	localparam int NUM_W  = sci_pkg::num_width(FRAC_BITS);
	localparam int SH_W   = NUM_W + 8;
	localparam int MQ_W   = sci_pkg::MQ_W;
	localparam int RC_W   = sci_pkg::RECIP_W;
	localparam int PROD_W = MQ_W + RC_W;

	logic signed [SH_W-1:0]  wide;
	logic [SH_W-1:0]         msh;
	logic                    valid_s4, valid_s5;
	logic [MQ_W-1:0]         mq_s4, mq_s5;
	logic                    neg_s4, neg_s5, sat_s4, sat_s5;
	sci_pkg::ctl_t           ctl_s4, ctl_s5;
	logic [PROD_W-1:0]       prod;
	logic [RC_W-1:0]         qe_s5;
	logic [6:0]              divisor;
	logic [MQ_W-1:0]         qm, rem;
	logic [RC_W:0]           q;
	sci_pkg::result_t        res_d;

	always_comb begin
		wide = (SH_W'(num_s3) <<< 8) >>> (FRAC_BITS - 8);
		msh  = $unsigned(wide) >> ctl_s3.sh;
	end

	assign prod = PROD_W'(mq_s4) * PROD_W'(ctl_s4.m125 ? sci_pkg::RECIP_125 : sci_pkg::RECIP_25);

	always_comb begin
		divisor = ctl_s5.m125 ? sci_pkg::DIV_125 : sci_pkg::DIV_25;
		qm      = MQ_W'(qe_s5) * MQ_W'(divisor);
		rem     = mq_s5 - qm;
		q       = (RC_W + 1)'(qe_s5) + (RC_W + 1)'(rem >= MQ_W'(divisor));
		res_d.status = ctl_s5.err;
		if (ctl_s5.err || neg_s5) begin
			res_d.coeff = '0;
		end else if (sat_s5 || (q > (RC_W + 1)'(sci_pkg::COEFF_MAX))) begin
			res_d.coeff = sci_pkg::COEFF_MAX;
		end else begin
			res_d.coeff = q[sci_pkg::COEFF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		mq_s4     <= msh[MQ_W-1:0];
		sat_s4    <= |msh[SH_W-1:MQ_W];
		neg_s4    <= wide[SH_W-1];
		ctl_s4    <= ctl_s3;
		qe_s5     <= prod[PROD_W-1:MQ_W];
		mq_s5     <= mq_s4;
		sat_s5    <= sat_s4;
		neg_s5    <= neg_s4;
		ctl_s5    <= ctl_s4;
		result_s6 <= res_d;
	end

endmodule
